[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the quiet-hours checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, off while reset is held
`define QH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qhwc check failed");

// same-cycle implication on a sequence, off while reset is held
`define QH_ASSERT_SEQ(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |-> (cons)) \
        else $error("qhwc check failed");

// next-cycle implication that also holds through reset
`define QH_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("qhwc check failed");

`endif

[hdl/qhwc_pkg.sv]
// ----------------------------------------------------------------------------
// qhwc_pkg
// types, constants and window compare shared by the quiet-hours checker
// ----------------------------------------------------------------------------
package qhwc_pkg;

    localparam int unsigned MinW       = 11;
    localparam int unsigned HourW      = 5;
    localparam int unsigned MinuteW    = 6;
    localparam int unsigned WeekdayW   = 3;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned CfgDataW   = 11;

    localparam logic [MinW:0]       DayMinutes      = 12'd1440;
    localparam logic [MinW:0]       OverrideMinutes = 12'd10;
    localparam logic [WeekdayW-1:0] FirstWeekendDay = 3'd6;

    // command codes
    localparam logic CmdCheck   = 1'b0;
    localparam logic CmdSuspend = 1'b1;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegW0Start     = 3'd0;
    localparam logic [CfgIdxW-1:0] RegW0End       = 3'd1;
    localparam logic [CfgIdxW-1:0] RegW1Start     = 3'd2;
    localparam logic [CfgIdxW-1:0] RegW1End       = 3'd3;
    localparam logic [CfgIdxW-1:0] RegWeekendMode = 3'd4;

    typedef struct packed {
        logic                command;
        logic [HourW-1:0]    hour;
        logic [MinuteW-1:0]  minute;
        logic [WeekdayW-1:0] weekday;
    } t_item;

    typedef struct packed {
        logic [MinW-1:0] w0_start;
        logic [MinW-1:0] w0_stop;
        logic [MinW-1:0] w1_start;
        logic [MinW-1:0] w1_stop;
        logic            weekend_mode;
    } t_cfg;

    typedef struct packed {
        logic            pending;
        logic [MinW-1:0] start;
        logic [MinW-1:0] stop;
    } t_susp;

    // half-open window [s, e), wraps past midnight when s > e, off when s == e
    function automatic logic in_window(
        input logic [MinW-1:0] t,
        input logic [MinW-1:0] s,
        input logic [MinW-1:0] e
    );
        logic hit;
        if (s == e) begin
            hit = 1'b0;
        end else if (s < e) begin
            hit = (t >= s) && (t < e);
        end else begin
            hit = (t < e) || (t >= s);
        end
        return hit;
    endfunction

endpackage

[hdl/quiet_hours_window_checker_core.sv]
// ----------------------------------------------------------------------------
// quiet_hours_window_checker_core
// decides per check beat whether the device sits in a blocked period
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  in        sink       i_in_valid / o_in_ready    i_command i_hour i_minute i_weekday
//  out       source     o_out_valid / i_out_ready  o_blocked
//  cfg       sink       i_cfg_we                   i_cfg_index i_cfg_data
//
//  one beat per cycle sustained while the result register is not stalled; a check
//  beat is loaded into the input register on acceptance, and its result then into
//  the result register behind the single evaluation stage
//  suspend beats give no result and leave the result register untouched
//  a stalled result register holds; the input register takes a new beat only
//  when its held beat makes no result or can drain into the result register
//  synchronous active-low reset clears config, override state and valid flags
//
module quiet_hours_window_checker_core import qhwc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item input
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [HourW-1:0]    i_hour,
    input  logic [MinuteW-1:0]  i_minute,
    input  logic [WeekdayW-1:0] i_weekday,
    // result output
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_blocked,
    // config writes
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    // input register
    logic  r_in_vld;
    t_item r_in;
    // result register
    logic  r_out_vld;
    logic  r_blocked;
    // config and override state
    t_cfg  r_cfg;
    t_cfg  n_cfg;
    t_susp r_susp;
    t_susp n_susp;

    logic  w_has_result;
    logic  w_blocked;
    logic  w_advance;
    logic  w_in_take;

    qhwc_eval u_eval (
        .i_item       (r_in),
        .i_cfg        (r_cfg),
        .i_susp       (r_susp),
        .o_has_result (w_has_result),
        .o_blocked    (w_blocked),
        .o_susp_next  (n_susp)
    );

    // the held beat moves on if it makes no result or the result slot frees up
    assign w_advance   = r_in_vld && (!w_has_result || !r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_advance;
    assign w_in_take   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_blocked   = r_blocked;

    // register writes, unknown indexes ignored
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                RegW0Start:     n_cfg.w0_start     = i_cfg_data[MinW-1:0];
                RegW0End:       n_cfg.w0_stop      = i_cfg_data[MinW-1:0];
                RegW1Start:     n_cfg.w1_start     = i_cfg_data[MinW-1:0];
                RegW1End:       n_cfg.w1_stop      = i_cfg_data[MinW-1:0];
                RegWeekendMode: n_cfg.weekend_mode = i_cfg_data[0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cfg     <= '0;
            r_susp    <= '0;
        end else begin
            r_cfg <= n_cfg;
            if (w_in_take) begin
                r_in_vld <= 1'b1;
            end else if (w_advance) begin
                r_in_vld <= 1'b0;
            end
            if (w_advance) begin
                r_susp <= n_susp;
            end
            if (w_advance && w_has_result) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.command <= i_command;
            r_in.hour    <= i_hour;
            r_in.minute  <= i_minute;
            r_in.weekday <= i_weekday;
        end
        if (w_advance && w_has_result) begin
            r_blocked <= w_blocked;
        end
    end

endmodule

[hdl/qhwc_eval.sv]
// ----------------------------------------------------------------------------
// qhwc_eval
// evaluates one item against the windows and the suspend override
// ----------------------------------------------------------------------------
module qhwc_eval import qhwc_pkg::*; (
    input  t_item i_item,
    input  t_cfg  i_cfg,
    input  t_susp i_susp,
    output logic  o_has_result,
    output logic  o_blocked,
    output t_susp o_susp_next
);

    logic [MinW-1:0] w_tod;
    logic [MinW:0]   w_sum;
    logic [MinW-1:0] w_stop;
    logic            w_hit0;
    logic            w_hit1;
    logic            w_weekend;

    // hour*60 as hour*64 - hour*4, no wrap at day end
    assign w_tod = {i_item.hour, 6'b0}
                 - {4'b0, i_item.hour, 2'b0}
                 + {5'b0, i_item.minute};

    always_comb begin
        w_sum = {1'b0, w_tod} + OverrideMinutes;
        if (w_sum > DayMinutes) begin
            w_sum = w_sum - DayMinutes;
        end
        w_stop = w_sum[MinW-1:0];
    end

    assign w_hit0    = in_window(w_tod, i_cfg.w0_start, i_cfg.w0_stop);
    assign w_hit1    = in_window(w_tod, i_cfg.w1_start, i_cfg.w1_stop);
    assign w_weekend = (i_item.weekday >= FirstWeekendDay);

    always_comb begin
        o_susp_next  = i_susp;
        o_has_result = 1'b1;
        o_blocked    = 1'b0;
        if (i_item.command == CmdSuspend) begin
            o_has_result        = 1'b0;
            o_susp_next.pending = 1'b1;
        end else if (i_susp.pending) begin
            // open the override from this minute
            o_susp_next.pending = 1'b0;
            o_susp_next.start   = w_tod;
            o_susp_next.stop    = w_stop;
        end else if (in_window(w_tod, i_susp.start, i_susp.stop)) begin
            o_blocked = 1'b0;
        end else begin
            o_susp_next.start = '0;
            o_susp_next.stop  = '0;
            if (!i_cfg.weekend_mode) begin
                o_blocked = w_hit0 || w_hit1;
            end else if (w_weekend) begin
                o_blocked = w_hit1;
            end else begin
                o_blocked = w_hit0;
            end
        end
    end

endmodule

[hdl/qhwc_checker.sv]
// ----------------------------------------------------------------------------
// qhwc_checker
// port-level checks on the quiet-hours checker, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qhwc_checker import qhwc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_blocked
);

    // result stays up while stalled
    `QH_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    // stalled result keeps its value
    `QH_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_blocked))
    // a blocked check behind a stalled result stays blocked while the stall lasts
    `QH_ASSERT_SEQ(a_in_stall, (o_out_valid && !i_out_ready && !o_in_ready) ##1 !i_out_ready, !o_in_ready)
    // reset empties both registers
    `QH_ASSERT_ALWAYS(a_rst_empty, !i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind quiet_hours_window_checker_core qhwc_checker u_qhwc_checker (.*);
